### design/mide_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mide_pkg
// Shared types and constants for the multi-input debouncer with edge events.
// ----------------------------------------------------------------------------
package mide_pkg;

    localparam int unsigned LEVEL_BITS     = 16;
    localparam int unsigned NUM_INPUTS_DEF = 16;
    localparam int unsigned TICKS_W        = 10;
    localparam int unsigned INDEX_W        = 4;
    localparam logic [TICKS_W-1:0] SETTLE_RESET = 10'd20;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // take the input beat
        logic load_out;  // latch the event at the scan position
        logic advance;   // step the scan position
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_events; // presented sample ends the settle phase with changes
        logic bit_set;    // scan position holds a pending change
        logic out_last;   // event on the output is the final one
    } t_dp_sts;

endpackage : mide_pkg
`default_nettype wire

### design/mide_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mide_ctrl
// Sequencer: accepts beats while idle, walks the pending changes and hands
// each event to the output channel.
// ----------------------------------------------------------------------------
module mide_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    input  wire mide_pkg::t_dp_sts i_sts,
    output mide_pkg::t_dp_cmd o_cmd
);
    import mide_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.has_events) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.bit_set) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_EMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = i_sts.out_last ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule : mide_ctrl
`default_nettype wire

### design/mide_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mide_dp
// Datapath: settle timer, stored levels, pending-change vector, scan position
// and the output event register.
// ----------------------------------------------------------------------------
module mide_dp #(
    parameter int unsigned NUM_INPUTS = mide_pkg::NUM_INPUTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [mide_pkg::TICKS_W-1:0]       i_cfg_data,
    input  wire                               i_kind,
    input  wire [mide_pkg::LEVEL_BITS-1:0]    i_pin_levels,
    input  wire mide_pkg::t_dp_cmd            i_cmd,
    output mide_pkg::t_dp_sts                 o_sts,
    output logic [mide_pkg::INDEX_W-1:0]      o_input_index,
    output logic                              o_rising,
    output logic                              o_last
);
    import mide_pkg::*;

    localparam int unsigned W     = (NUM_INPUTS > LEVEL_BITS) ? LEVEL_BITS : NUM_INPUTS;
    localparam int unsigned IDX_W = (W > 1) ? $clog2(W) : 1;

    logic [TICKS_W-1:0] r_settle_ticks;
    logic [TICKS_W-1:0] r_count;
    logic [W-1:0]       r_stored;
    logic [W-1:0]       r_pins;
    logic [W-1:0]       r_pend;
    logic [IDX_W-1:0]   r_idx;
    logic               r_primed;
    logic               r_settling;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_rising;
    logic               r_out_last;

    logic [W-1:0] pins;
    logic [W-1:0] changed;
    logic [W-1:0] pend_clr;
    logic         count_zero;

    assign pins       = i_pin_levels[W-1:0];
    assign changed    = pins ^ r_stored;
    assign count_zero = (r_count == '0);
    assign pend_clr   = r_pend & ~(W'(1) << r_idx);

    assign o_sts.has_events = (i_kind == KIND_SAMPLE) && r_primed && count_zero
                              && r_settling && (changed != '0);
    assign o_sts.bit_set    = r_pend[r_idx];
    assign o_sts.out_last   = r_out_last;

    assign o_input_index = INDEX_W'(r_out_idx);
    assign o_rising      = r_out_rising;
    assign o_last        = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RESET;
        end else if (i_cfg_we) begin
            r_settle_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_stored   <= '0;
            r_primed   <= 1'b0;
            r_settling <= 1'b0;
            r_pend     <= '0;
            r_idx      <= '0;
        end else if (i_cmd.accept) begin
            if (i_kind == KIND_TICK) begin
                if (!count_zero) begin
                    r_count <= r_count - 1'b1;
                end
            end else if (!r_primed) begin
                r_stored <= pins;
                r_primed <= 1'b1;
            end else if (count_zero) begin
                if ((changed != '0) && !r_settling) begin
                    // start settling, keep the old levels
                    r_settling <= 1'b1;
                    r_count    <= r_settle_ticks;
                end else begin
                    r_stored   <= pins;
                    r_settling <= 1'b0;
                    if (r_settling) begin
                        r_pend <= changed;
                        r_idx  <= '0;
                    end
                end
            end
        end else if (i_cmd.load_out) begin
            r_pend <= pend_clr;
            r_idx  <= r_idx + 1'b1;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // pins of the last accepted beat (the closing sample of a burst), source of the edge direction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pins <= pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_idx    <= r_idx;
            r_out_rising <= r_pins[r_idx];
            r_out_last   <= (pend_clr == '0);
        end
    end

endmodule : mide_dp
`default_nettype wire

### design/multi_input_debounce_edge_events_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_input_debounce_edge_events_top
// Debouncer for a group of inputs sharing one settle timer, with per-input
// edge events.
// ----------------------------------------------------------------------------
// Ticks and samples are taken one beat per cycle while no events are pending.
// The first sample after reset only loads the levels. A sample that differs
// from the stored levels starts the shared timer at settle_ticks; samples are
// ignored until that many ticks have passed. The next sample then stores the
// levels and, if any input still differs, emits one event per such input in
// ascending index order, the final one marked with last. During that burst
// the input is stalled: the scanner visits one input position per cycle up to
// the highest changed input, pausing at each event it hands out until the
// output takes it.
// settle_ticks may be written only while the block is idle.
// ----------------------------------------------------------------------------
module multi_input_debounce_edge_events_top #(
    parameter int unsigned NUM_INPUTS = mide_pkg::NUM_INPUTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [mide_pkg::TICKS_W-1:0]       i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_kind,
    input  wire [mide_pkg::LEVEL_BITS-1:0]    i_pin_levels,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [mide_pkg::INDEX_W-1:0]      o_input_index,
    output logic                              o_rising,
    output logic                              o_last
);
    import mide_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mide_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mide_dp #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_pin_levels  (i_pin_levels),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_input_index (o_input_index),
        .o_rising      (o_rising),
        .o_last        (o_last)
    );

endmodule : multi_input_debounce_edge_events_top
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shared-timer debouncer with edge events. A
// clocked driver feeds tick and sample beats from a queue and mirrors every
// accepted beat into a debounce predictor. A clocked monitor checks each
// event beat, field by field, against the oldest predicted event.
// ----------------------------------------------------------------------------
module testbench;
    import mide_pkg::*;

    localparam int unsigned NUM_IN      = NUM_INPUTS_DEF;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MASK =
        (NUM_IN >= LEVEL_BITS) ? '1 : LEVEL_BITS'((32'd1 << NUM_IN) - 1);
    localparam int unsigned DRAIN_WAIT  = 2 * LEVEL_BITS + 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 300;

    typedef struct packed {
        logic                  kind;
        logic [LEVEL_BITS-1:0] pins;
    } t_pin_beat;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               rising;
        logic               last;
    } t_edge_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [TICKS_W-1:0]    i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  i_kind = KIND_TICK;
    logic [LEVEL_BITS-1:0] i_pin_levels = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [INDEX_W-1:0]    o_input_index;
    logic                  o_rising;
    logic                  o_last;

    t_pin_beat   pending_beats[$];
    t_edge_event expected_edges[$];
    t_edge_event want_edge;

    // debounce predictor state
    logic [TICKS_W-1:0]    settle_cfg = SETTLE_RESET;
    logic [LEVEL_BITS-1:0] dbn_stored = '0;
    logic                  dbn_primed = 1'b0;
    logic                  dbn_settling = 1'b0;
    logic [TICKS_W-1:0]    dbn_count = '0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;

    multi_input_debounce_edge_events_top #(
        .NUM_INPUTS(NUM_IN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_pin_levels (i_pin_levels),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_input_index(o_input_index),
        .o_rising     (o_rising),
        .o_last       (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Advance the debounce state by one accepted beat and queue its edge events.
    task automatic predict_edges(input logic kind, input logic [LEVEL_BITS-1:0] raw);
        logic [LEVEL_BITS-1:0] pins;
        logic [LEVEL_BITS-1:0] diff;
        t_edge_event           ev;
        pins = raw & LEVEL_MASK;
        if (kind == KIND_TICK) begin
            if (dbn_count != 0) begin
                dbn_count = dbn_count - 1'b1;
            end
        end else if (!dbn_primed) begin
            dbn_stored = pins;
            dbn_primed = 1'b1;
        end else if (dbn_count == 0) begin
            diff = pins ^ dbn_stored;
            if (diff != 0 && !dbn_settling) begin
                dbn_settling = 1'b1;
                dbn_count    = settle_cfg;
            end else begin
                dbn_stored = pins;
                if (dbn_settling) begin
                    dbn_settling = 1'b0;
                    for (int i = 0; i < LEVEL_BITS; i++) begin
                        if (diff[i]) begin
                            ev.index  = INDEX_W'(i);
                            ev.rising = pins[i];
                            ev.last   = ((diff >> (i + 1)) == 0);
                            expected_edges.push_back(ev);
                        end
                    end
                end
            end
        end
    endtask

    // Driver: hold a stalled beat, otherwise offer the next pending one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_edges(i_kind, i_pin_levels);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid   <= 1'b1;
                    i_kind       <= pending_beats[0].kind;
                    i_pin_levels <= pending_beats[0].pins;
                    pending_beats.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, or forced high through a long hold-off.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        i_out_stall <= hold_request || (hold_left > 1) || ($urandom_range(99) < rx_idle_pct);
    end

    // Monitor: check every event beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_edges.size() == 0) begin
                report_mismatch($sformatf("event on input %0d with none expected",
                                          o_input_index));
            end else begin
                want_edge = expected_edges.pop_front();
                if (o_input_index !== want_edge.index) begin
                    report_mismatch($sformatf("input_index %0d, want %0d",
                                              o_input_index, want_edge.index));
                end
                if (o_rising !== want_edge.rising) begin
                    report_mismatch($sformatf("rising %b on input %0d, want %b",
                                              o_rising, want_edge.index, want_edge.rising));
                end
                if (o_last !== want_edge.last) begin
                    report_mismatch($sformatf("last %b on input %0d, want %b",
                                              o_last, want_edge.index, want_edge.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            report_mismatch($sformatf("timeout after %0d cycles, %0d events outstanding",
                                      cycle_count, expected_edges.size()));
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [LEVEL_BITS-1:0] rand_levels();
        return LEVEL_BITS'($urandom_range(65535));
    endfunction

    task automatic push_beat(input logic kind, input logic [LEVEL_BITS-1:0] pins);
        t_pin_beat b;
        b.kind = kind;
        b.pins = pins;
        pending_beats.push_back(b);
    endtask

    // One bounce: a change starts the timer, noisy samples fall inside the
    // settle window, then a closing sample. Now and then the tick run is cut
    // short so the closing sample lands while the timer still runs.
    task automatic push_bounce(input int unsigned settle);
        int unsigned ticks;
        ticks = settle;
        push_beat(KIND_SAMPLE, rand_levels());
        if (ticks != 0 && $urandom_range(9) == 0) begin
            ticks--;
        end
        for (int unsigned t = 0; t < ticks; t++) begin
            if ($urandom_range(3) == 0) begin
                push_beat(KIND_SAMPLE, rand_levels());
            end
            push_beat(KIND_TICK, rand_levels());
        end
        if ($urandom_range(4) == 0) begin
            push_beat(KIND_TICK, rand_levels());
        end
        push_beat(KIND_SAMPLE, rand_levels());
        if ($urandom_range(4) == 0) begin
            push_beat(1'($urandom_range(1)), rand_levels());
        end
    endtask

    // Wait until every beat is taken and every event has come, then let the
    // scanner settle.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_beats.size() != 0 || i_in_valid || expected_edges.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_settle(input logic [TICKS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settle_cfg = value;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 6;
        rx_idle_pct = 87;
        write_settle(10'd2);

        // directed: stopped-timer tick, initial load, no-change sample,
        // full-width falling and rising bursts, ignored sample while settling,
        // expiry with nothing left changed, scattered all-falling burst
        push_beat(KIND_TICK,   16'hFFFF);
        push_beat(KIND_SAMPLE, 16'hFFFF);
        push_beat(KIND_SAMPLE, 16'hFFFF);
        push_beat(KIND_SAMPLE, 16'h0000);
        push_beat(KIND_SAMPLE, 16'h1234);
        push_beat(KIND_TICK,   16'h0000);
        push_beat(KIND_TICK,   16'hFFFF);
        push_beat(KIND_SAMPLE, 16'h0000);
        push_beat(KIND_SAMPLE, 16'hFFFF);
        push_beat(KIND_TICK,   16'h0000);
        push_beat(KIND_TICK,   16'h0000);
        push_beat(KIND_SAMPLE, 16'hFFFF);
        push_beat(KIND_SAMPLE, 16'h8001);
        push_beat(KIND_TICK,   16'h0000);
        push_beat(KIND_TICK,   16'h0000);
        push_beat(KIND_SAMPLE, 16'hFFFF);
        push_beat(KIND_SAMPLE, 16'h0001);
        push_beat(KIND_TICK,   16'h0000);
        push_beat(KIND_TICK,   16'h0000);
        push_beat(KIND_SAMPLE, 16'h5A5A);
        push_beat(KIND_TICK,   16'h0000);
        wait_drained();

        // zero settle time: the next sample closes the settle phase at once
        write_settle(10'd0);
        push_beat(KIND_SAMPLE, 16'h0F0F);
        push_beat(KIND_SAMPLE, 16'h0F0F);
        push_beat(KIND_TICK,   16'hFFFF);
        wait_drained();

        write_settle(10'd1);
        repeat (6) push_bounce(1);
        wait_drained();

        tx_idle_pct = 87;
        rx_idle_pct = 6;
        write_settle(10'd3);
        repeat (4) push_bounce(3);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // long output hold-off while beats keep coming, so the input backs up
        write_settle(10'd4);
        @(posedge i_clk);
        hold_request <= 1'b1;
        @(posedge i_clk);
        hold_request <= 1'b0;
        repeat (3) push_bounce(4);
        // sender pause until every event is out
        wait_drained();
        repeat (3) push_bounce(4);
        wait_drained();

        if (expected_edges.size() != 0) begin
            report_mismatch($sformatf("%0d events never came", expected_edges.size()));
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
